// ===== rtl/core/lobm_pkg.sv =====
// Shared types and constants of the limit order book matcher.
`timescale 1ns / 1ps
package lobm_pkg;

  localparam int SIDE_DEPTH   = 32;
  localparam int PRICE_BITS   = 16;
  localparam int IDX_W        = (SIDE_DEPTH > 1) ? $clog2(SIDE_DEPTH) : 1;
  localparam int CNT_W        = $clog2(SIDE_DEPTH + 1);
  localparam int ORDER_CNT_W  = 7;

  typedef logic [PRICE_BITS-1:0] price_t;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_SUBMIT = 2'd1;
  localparam logic [1:0] OP_CANCEL = 2'd2;
  localparam logic [1:0] OP_MODIFY = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DUP_ID    = 2'd1;
  localparam logic [1:0] ST_UNKNOWN   = 2'd2;
  localparam logic [1:0] ST_BOOK_FULL = 2'd3;

  typedef struct packed {
    logic [31:0] ident;
    price_t      level;
    logic [31:0] amount;
  } entry_t;

  typedef enum logic [1:0] {
    BK_NOP,
    BK_REMOVE,
    BK_APPEND,
    BK_SET_AMT
  } book_cmd_t;

  typedef struct packed {
    book_cmd_t        cmd;
    logic [IDX_W-1:0] idx;
    entry_t           entry;
  } book_req_t;

  typedef struct packed {
    logic load_nb;
    logic load_new;
    logic set_amt;
  } cell_ctl_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
    entry_t           entry;
  } book_find_t;

  typedef struct packed {
    logic   done;
    logic   found;
    entry_t entry;
    logic [IDX_W-1:0] idx;
  } book_best_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] order_id;
    logic        is_buy;
    logic        is_market;
    logic [15:0] price;
    logic [31:0] quantity;
    logic [63:0] timestamp;
  } in_item_t;

  typedef struct packed {
    logic        is_trade;
    logic [31:0] buyer_id;
    logic [31:0] seller_id;
    logic [15:0] trade_price;
    logic [31:0] trade_quantity;
    logic [63:0] trade_time;
    logic        last;
    logic [1:0]  status;
    logic [15:0] best_bid;
    logic [15:0] best_ask;
    logic [ORDER_CNT_W-1:0] order_count;
  } out_item_t;

endpackage

// ===== rtl/core/lobm_cell.sv =====
// One slot of a book: holds an order, loads from its upper neighbor on a shift, takes a fresh order or a new amount.
`timescale 1ns / 1ps
module lobm_cell import lobm_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  entry_t    nb,
  input  entry_t    fresh,
  output entry_t    ent
);

  always_ff @(posedge clk) begin
    priority if (ctl.load_nb) begin
      ent <= nb;
    end else if (ctl.load_new) begin
      ent <= fresh;
    end else if (ctl.set_amt) begin
      ent.amount <= fresh.amount;
    end else begin
      ent <= ent;
    end
  end

endmodule

// ===== rtl/core/lobm_book.sv =====
// One side of the book: chain of cells in arrival order, id lookup and best-price scan.
`timescale 1ns / 1ps
module lobm_book import lobm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             is_bid,
  input  book_req_t        req,
  input  logic [31:0]      find_id,
  input  logic             scan_start,
  output book_find_t       find,
  output book_best_t       best,
  output logic [CNT_W-1:0] count
);

  entry_t ents [SIDE_DEPTH];

  genvar i;
  generate
    for (i = 0; i < SIDE_DEPTH; i++) begin : g_cell
      cell_ctl_t ctl;
      entry_t    nb;
      if (i + 1 < SIDE_DEPTH) begin : g_nb
        assign nb = ents[i+1];
      end else begin : g_end
        assign nb = '0;
      end
      assign ctl.load_nb  = (req.cmd == BK_REMOVE) && (CNT_W'(i) >= CNT_W'(req.idx)) &&
                            (CNT_W'(i + 1) < count);
      assign ctl.load_new = (req.cmd == BK_APPEND) && (CNT_W'(i) == count);
      assign ctl.set_amt  = (req.cmd == BK_SET_AMT) && (req.idx == IDX_W'(i));
      lobm_cell u_cell (
        .clk   (clk),
        .ctl   (ctl),
        .nb    (nb),
        .fresh (req.entry),
        .ent   (ents[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (req.cmd == BK_APPEND) begin
      count <= count + 1'b1;
    end else if (req.cmd == BK_REMOVE) begin
      count <= count - 1'b1;
    end
  end

  // lowest matching slot wins
  always_comb begin
    find.hit = 1'b0;
    find.idx = '0;
    for (int k = SIDE_DEPTH - 1; k >= 0; k--) begin
      if (CNT_W'(k) < count && ents[k].ident == find_id) begin
        find.hit = 1'b1;
        find.idx = IDX_W'(k);
      end
    end
    find.entry = ents[find.idx];
  end

  // best scan: one slot per cycle, strict compare keeps earliest arrival
  logic             busy;
  logic [CNT_W-1:0] ptr;
  logic             found;
  logic [IDX_W-1:0] bidx;
  price_t           blevel;
  entry_t           cur;
  logic             better;

  assign cur    = ents[ptr[IDX_W-1:0]];
  assign better = is_bid ? (cur.level > blevel) : (cur.level < blevel);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      ptr   <= '0;
      found <= 1'b0;
    end else if (scan_start) begin
      busy  <= 1'b1;
      ptr   <= '0;
      found <= 1'b0;
    end else if (busy) begin
      if (ptr == count) begin
        busy <= 1'b0;
      end else begin
        if (!found || better) begin
          found  <= 1'b1;
          bidx   <= ptr[IDX_W-1:0];
          blevel <= cur.level;
        end
        ptr <= ptr + 1'b1;
      end
    end
  end

  assign best.done  = !busy;
  assign best.found = found;
  assign best.idx   = bidx;
  assign best.entry = ents[bidx];

endmodule

// ===== rtl/core/limit_order_book_matcher.sv =====
// Top level of the price-time priority limit order book matcher.
`timescale 1ns / 1ps
// Usage:
//  item channel (item_valid / item_stall / item) carries one order transaction:
//  add, submit, cancel or modify. The block takes one transaction at a time and
//  holds item_stall high until its last result has been registered.
//  result channel (result_valid / result_stall / result) returns zero or more
//  trade records (submit only) followed by one status record with last set.
//  Each book is a chain of cells kept in arrival order; removal shifts the
//  upper cells down by one all together, appends go to the tail.
//  Finding the best resting order is a scan of one cell per cycle over the
//  orders on that side.
//  Add, cancel, modify: dispatch, an append for a modify that moves, then the status scan of both books.
//  Submit: a scan of the opposite book and an emit per trade, then the status scan.
//  A stalled result holds in the output register; the engine waits until the
//  register drains before writing the next record.
//  Reset (synchronous, active high) empties both books and the output register.
module limit_order_book_matcher import lobm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  in_item_t  item,
  output logic      result_valid,
  input  logic      result_stall,
  output out_item_t result
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_MOD_APPEND,
    S_SUB_SCAN,
    S_SUB_WAIT,
    S_SUB_EMIT,
    S_SUB_REST,
    S_STAT_SCAN,
    S_STAT_WAIT,
    S_STAT_EMIT
  } state_t;

  state_t      state;
  in_item_t    cur;
  logic [31:0] qty;
  logic [1:0]  status;
  logic        mod_bid;

  book_req_t        req, nop_req, bid_req, ask_req;
  logic             tgt_bid;
  logic             bid_scan, ask_scan;
  book_find_t       bid_find, ask_find;
  book_best_t       bid_best, ask_best;
  logic [CNT_W-1:0] bid_count, ask_count;

  lobm_book u_bid (
    .clk (clk), .rst (rst), .is_bid (1'b1), .req (bid_req), .find_id (cur.order_id),
    .scan_start (bid_scan), .find (bid_find), .best (bid_best), .count (bid_count)
  );

  lobm_book u_ask (
    .clk (clk), .rst (rst), .is_bid (1'b0), .req (ask_req), .find_id (cur.order_id),
    .scan_start (ask_scan), .find (ask_find), .best (ask_best), .count (ask_count)
  );

  logic       any_hit, own_full, slot_free, cross_ok;
  book_best_t opp_best;
  book_find_t hit_find;
  entry_t     fresh;
  logic [31:0] fill, left;
  logic        emit;
  out_item_t   result_next;

  assign any_hit   = bid_find.hit || ask_find.hit;
  assign own_full  = cur.is_buy ? (bid_count == CNT_W'(SIDE_DEPTH))
                                : (ask_count == CNT_W'(SIDE_DEPTH));
  assign slot_free = !result_valid || !result_stall;
  assign opp_best  = cur.is_buy ? ask_best : bid_best;
  assign hit_find  = bid_find.hit ? bid_find : ask_find;
  assign cross_ok  = cur.is_market ||
                     (cur.is_buy ? (opp_best.entry.level <= price_t'(cur.price))
                                 : (opp_best.entry.level >= price_t'(cur.price)));
  assign fill      = (qty < opp_best.entry.amount) ? qty : opp_best.entry.amount;
  assign left      = opp_best.entry.amount - fill;
  assign fresh     = '{ident: cur.order_id, level: price_t'(cur.price), amount: qty};

  // book commands for this cycle
  always_comb begin
    nop_req  = '{cmd: BK_NOP, idx: '0, entry: '0};
    req      = nop_req;
    tgt_bid  = cur.is_buy;
    bid_scan = 1'b0;
    ask_scan = 1'b0;
    unique case (state)
      S_DISPATCH: begin
        unique case (cur.operation)
          OP_ADD: begin
            if (!any_hit && !own_full) req = '{cmd: BK_APPEND, idx: '0, entry: fresh};
          end
          OP_CANCEL, OP_MODIFY: begin
            tgt_bid = bid_find.hit;
            if (any_hit) begin
              if (cur.operation == OP_MODIFY &&
                  hit_find.entry.level == price_t'(cur.price) &&
                  qty <= hit_find.entry.amount) begin
                req = '{cmd: BK_SET_AMT, idx: hit_find.idx, entry: fresh};
              end else begin
                req = '{cmd: BK_REMOVE, idx: hit_find.idx, entry: fresh};
              end
            end
          end
          default: ;
        endcase
      end
      S_MOD_APPEND: begin
        tgt_bid = mod_bid;
        req     = '{cmd: BK_APPEND, idx: '0, entry: fresh};
      end
      S_SUB_SCAN: begin
        if (qty != 32'd0) begin
          bid_scan = !cur.is_buy;
          ask_scan = cur.is_buy;
        end
      end
      S_SUB_EMIT: begin
        tgt_bid = !cur.is_buy;
        if (slot_free) begin
          if (left == 32'd0) begin
            req = '{cmd: BK_REMOVE, idx: opp_best.idx, entry: '0};
          end else begin
            req = '{cmd: BK_SET_AMT, idx: opp_best.idx,
                    entry: '{ident: '0, level: '0, amount: left}};
          end
        end
      end
      S_SUB_REST: begin
        if (qty != 32'd0 && !cur.is_market && !any_hit && !own_full)
          req = '{cmd: BK_APPEND, idx: '0, entry: fresh};
      end
      S_STAT_SCAN: begin
        bid_scan = 1'b1;
        ask_scan = 1'b1;
      end
      default: ;
    endcase
    bid_req = tgt_bid ? req : nop_req;
    ask_req = tgt_bid ? nop_req : req;
  end

  // record loaded into the output register this cycle
  always_comb begin
    emit        = 1'b0;
    result_next = '0;
    if (state == S_SUB_EMIT && slot_free) begin
      emit                       = 1'b1;
      result_next.is_trade       = 1'b1;
      result_next.buyer_id       = cur.is_buy ? cur.order_id : opp_best.entry.ident;
      result_next.seller_id      = cur.is_buy ? opp_best.entry.ident : cur.order_id;
      result_next.trade_price    = 16'(opp_best.entry.level);
      result_next.trade_quantity = fill;
      result_next.trade_time     = cur.timestamp;
    end else if (state == S_STAT_EMIT && slot_free) begin
      emit                    = 1'b1;
      result_next.last        = 1'b1;
      result_next.status      = status;
      result_next.best_bid    = bid_best.found ? 16'(bid_best.entry.level) : 16'd0;
      result_next.best_ask    = ask_best.found ? 16'(ask_best.entry.level) : 16'd0;
      result_next.order_count = ORDER_CNT_W'(bid_count) + ORDER_CNT_W'(ask_count);
    end
  end

  assign item_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (emit) begin
        result_valid <= 1'b1;
        result       <= result_next;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            cur    <= item;
            qty    <= item.quantity;
            status <= ST_OK;
            state  <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          unique case (cur.operation)
            OP_ADD: begin
              state <= S_STAT_SCAN;
              if (any_hit) status <= ST_DUP_ID;
              else if (own_full) status <= ST_BOOK_FULL;
            end
            OP_SUBMIT: state <= S_SUB_SCAN;
            OP_CANCEL: begin
              state <= S_STAT_SCAN;
              if (!any_hit) status <= ST_UNKNOWN;
            end
            OP_MODIFY: begin
              mod_bid <= bid_find.hit;
              if (!any_hit) begin
                status <= ST_UNKNOWN;
                state  <= S_STAT_SCAN;
              end else if (!(hit_find.entry.level == price_t'(cur.price) &&
                             qty <= hit_find.entry.amount)) begin
                state <= S_MOD_APPEND;
              end else begin
                state <= S_STAT_SCAN;
              end
            end
            default: state <= S_STAT_SCAN;
          endcase
        end
        S_MOD_APPEND: state <= S_STAT_SCAN;
        S_SUB_SCAN: state <= (qty == 32'd0) ? S_SUB_REST : S_SUB_WAIT;
        S_SUB_WAIT: begin
          if (opp_best.done) begin
            state <= (opp_best.found && cross_ok) ? S_SUB_EMIT : S_SUB_REST;
          end
        end
        S_SUB_EMIT: begin
          if (slot_free) begin
            qty   <= qty - fill;
            state <= S_SUB_SCAN;
          end
        end
        S_SUB_REST: begin
          if (qty != 32'd0 && !cur.is_market) begin
            if (any_hit) status <= ST_DUP_ID;
            else if (own_full) status <= ST_BOOK_FULL;
          end
          state <= S_STAT_SCAN;
        end
        S_STAT_SCAN: state <= S_STAT_WAIT;
        S_STAT_WAIT: begin
          if (bid_best.done && ask_best.done) state <= S_STAT_EMIT;
        end
        S_STAT_EMIT: begin
          if (slot_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
